// ----- src/mir_pkg.sv -----
// ----------------------------------------------------------------------------
// mir_pkg
// Shared types and fixed constants for the masked image RMSE block.
// ----------------------------------------------------------------------------
package mir_pkg;

  // Fixed field widths of the stream payload.
  localparam int CH_W      = 16;
  localparam int RMSE_W    = 17;
  localparam int CNT_OUT_W = 23;

  // Accumulator and result arithmetic widths.
  localparam int SUM_W  = 64;
  localparam int ROOT_W = SUM_W / 2;
  localparam int SREM_W = ROOT_W + 1;

  // Iteration counts of the shared divide and square-root unit.
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // pixel transfers are allowed
    logic load;       // move the image totals into the divider, clear totals
    logic div_step;   // one restoring-division step
    logic sqrt_step;  // one square-root step
    logic res_load;   // capture the result into the output register
  } mir_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_done;  // the last pixel of an image has been accumulated
    logic out_free;   // the output register can take a new result
  } mir_status_t;

endpackage

// ----- src/masked_image_rmse.sv -----
// ----------------------------------------------------------------------------
// masked_image_rmse
// Masked root-mean-square colour error between a test and a reference image
// streamed as pixel pairs; one result per image.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata (low bit up)                       tuser          tlast
//  in_      slave      test r,g,b, ref r,g,b (6 x 16 bits)      pixel_enabled  last_pixel
//  out_     master     rmse_value (17), counted_pixels (23)     empty_flag     -
//
//  Pixels transfer one per clock cycle while an image is open.
//  After the last pixel, the input stalls through the pipeline drain, the load,
//  64 restoring-division steps and 32 square-root steps in the shared
//  divide/root unit, then the result load.
//  The result sits in an output register; pixels of the next image are taken
//  while it waits, and only the next image's result load waits on it.
//  Reset is synchronous, active low, and clears the totals and the control.
// ----------------------------------------------------------------------------
module masked_image_rmse #(
  parameter int MAX_PIXELS   = 4194304,
  parameter int CHANNEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // test_red, test_green, test_blue, ref_red, ref_green, ref_blue
  input  logic        in_tuser,   // pixel_enabled
  input  logic        in_tlast,   // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // rmse_value [16:0], counted_pixels [39:17]
  output logic        out_tuser   // empty_flag
);

  mir_pkg::mir_cmd_t    cmd;
  mir_pkg::mir_status_t status;

  logic [mir_pkg::RMSE_W-1:0]    res_rmse;
  logic [mir_pkg::CNT_OUT_W-1:0] res_count;
  logic                          in_acc_last;

  assign in_tready   = cmd.take;
  assign in_acc_last = in_tvalid && cmd.take && in_tlast;

  mir_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc_last (in_acc_last),
    .status      (status),
    .cmd         (cmd)
  );

  mir_datapath #(
    .MAX_PIXELS   (MAX_PIXELS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .pix_valid (in_tvalid),
    .pix_data  (in_tdata),
    .pix_en    (in_tuser),
    .pix_last  (in_tlast),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_rmse  (res_rmse),
    .res_count (res_count),
    .res_empty (out_tuser)
  );

  assign out_tdata = {res_count, res_rmse};

endmodule

// ----- src/mir_ctrl.sv -----
// ----------------------------------------------------------------------------
// mir_ctrl
// Controller: sequences pixel accumulation, drain, divide, square root and
// result hand-off.
// ----------------------------------------------------------------------------
module mir_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc_last,  // last pixel transferred this cycle
  input  mir_pkg::mir_status_t status,
  output mir_pkg::mir_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_ACCUM,
    S_DRAIN,
    S_LOAD,
    S_DIV,
    S_SQRT,
    S_RESULT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [mir_pkg::STEP_W-1:0] step_r, step_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_ACCUM: begin
        if (in_acc_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (status.last_done) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_DIV;
        step_nxt  = '0;
      end
      S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == mir_pkg::STEP_W'(mir_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_SQRT;
          step_nxt  = '0;
        end
      end
      S_SQRT: begin
        step_nxt = step_r + 1'b1;
        if (step_r == mir_pkg::STEP_W'(mir_pkg::SQRT_STEPS - 1)) begin
          state_nxt = S_RESULT;
          step_nxt  = '0;
        end
      end
      S_RESULT: begin
        if (status.out_free) state_nxt = S_ACCUM;
      end
      default: begin
        state_nxt = S_ACCUM;
        step_nxt  = '0;
      end
    endcase
  end

  // State and step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCUM;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Commands decoded from the current state.
  always_comb begin
    cmd           = '0;
    cmd.take      = (state_r == S_ACCUM);
    cmd.load      = (state_r == S_LOAD);
    cmd.div_step  = (state_r == S_DIV);
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.res_load  = (state_r == S_RESULT) && status.out_free;
  end

endmodule

// ----- src/mir_datapath.sv -----
// ----------------------------------------------------------------------------
// mir_datapath
// Datapath: pixel difference and square pipeline, saturating accumulator,
// shared restoring divider and square-root unit, and output register.
// ----------------------------------------------------------------------------
module mir_datapath #(
  parameter int MAX_PIXELS   = 4194304,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mir_pkg::mir_cmd_t                   cmd,
  output mir_pkg::mir_status_t                status,
  // Pixel input.
  input  logic                                pix_valid,
  input  logic [6*mir_pkg::CH_W-1:0]          pix_data,
  input  logic                                pix_en,
  input  logic                                pix_last,
  // Result output.
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [mir_pkg::RMSE_W-1:0]          res_rmse,
  output logic [mir_pkg::CNT_OUT_W-1:0]       res_count,
  output logic                                res_empty
);

  // Channel bits in use, pixel count width and per-pixel error width.
  localparam int CW   = (CHANNEL_BITS < mir_pkg::CH_W) ? CHANNEL_BITS : mir_pkg::CH_W;
  localparam int CNTW = $clog2(MAX_PIXELS + 1);
  localparam int SQW  = 2 * CW;
  localparam int EW   = SQW + 2;

  logic take_pix;
  assign take_pix = pix_valid && cmd.take;

  // Stage 1: absolute channel differences.
  logic          s1_valid_r, s1_en_r, s1_last_r;
  logic [CW-1:0] dif_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= take_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pix) begin
      s1_en_r   <= pix_en;
      s1_last_r <= pix_last;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_diff
    logic [CW-1:0] a, b;
    assign a = pix_data[ch*mir_pkg::CH_W +: CW];
    assign b = pix_data[(ch+3)*mir_pkg::CH_W +: CW];
    always_ff @(posedge clk) begin
      if (take_pix) begin
        dif_r[ch] <= (a >= b) ? (a - b) : (b - a);
      end
    end
  end

  // Stage 2: squared differences.
  logic           s2_valid_r, s2_en_r, s2_last_r;
  logic [SQW-1:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_en_r   <= s1_en_r;
      s2_last_r <= s1_last_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQW'({{CW{1'b0}}, dif_r[i]} * {{CW{1'b0}}, dif_r[i]});
      end
    end
  end

  // Stage 3: saturating accumulation of the pixel error.
  logic [mir_pkg::SUM_W-1:0] sum_r;
  logic [CNTW-1:0]           count_r;
  logic [EW-1:0]             pix_err;
  logic [mir_pkg::SUM_W:0]   acc_wide;
  logic                      acc_en;

  assign pix_err  = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
  assign acc_wide = {1'b0, sum_r} + {{(mir_pkg::SUM_W + 1 - EW){1'b0}}, pix_err};
  assign acc_en   = s2_valid_r && s2_en_r && (count_r < CNTW'(MAX_PIXELS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (cmd.load) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (acc_en) begin
      sum_r   <= acc_wide[mir_pkg::SUM_W] ? '1 : acc_wide[mir_pkg::SUM_W-1:0];
      count_r <= count_r + 1'b1;
    end
  end

  // Shared divide and square-root unit. The quotient register is reused
  // as the radicand shifter once the division is done.
  logic [mir_pkg::SUM_W-1:0]  quo_r;
  logic [CNTW-1:0]            drem_r;
  logic [CNTW-1:0]            divisor_r;
  logic [mir_pkg::SREM_W-1:0] srem_r;
  logic [mir_pkg::ROOT_W-1:0] root_r;

  logic [CNTW:0]                drem_sh, drem_diff;
  logic                         div_ge;
  logic [mir_pkg::SREM_W+1:0]   srem_sh, srem_trial, srem_diff;
  logic                         sqrt_ge;

  assign drem_sh   = {drem_r, quo_r[mir_pkg::SUM_W-1]};
  assign drem_diff = drem_sh - {1'b0, divisor_r};
  assign div_ge    = (drem_sh >= {1'b0, divisor_r});

  assign srem_sh    = {srem_r, quo_r[mir_pkg::SUM_W-1 -: 2]};
  assign srem_trial = {1'b0, root_r, 2'b01};
  assign srem_diff  = srem_sh - srem_trial;
  assign sqrt_ge    = (srem_sh >= srem_trial);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r     <= sum_r;
      drem_r    <= '0;
      divisor_r <= count_r;
      srem_r    <= '0;
      root_r    <= '0;
    end else if (cmd.div_step) begin
      drem_r <= div_ge ? drem_diff[CNTW-1:0] : drem_sh[CNTW-1:0];
      quo_r  <= {quo_r[mir_pkg::SUM_W-2:0], div_ge};
    end else if (cmd.sqrt_step) begin
      srem_r <= sqrt_ge ? srem_diff[mir_pkg::SREM_W-1:0] : srem_sh[mir_pkg::SREM_W-1:0];
      root_r <= {root_r[mir_pkg::ROOT_W-2:0], sqrt_ge};
      quo_r  <= {quo_r[mir_pkg::SUM_W-3:0], 2'b00};
    end
  end

  // Output register; the count is cut to the output field width.
  logic                            out_valid_r;
  logic [mir_pkg::RMSE_W-1:0]      out_rmse_r;
  logic [mir_pkg::CNT_OUT_W-1:0]   out_count_r;
  logic                            out_empty_r;
  logic [CNTW+mir_pkg::CNT_OUT_W-1:0] count_ext;
  logic                            no_pixels;

  assign count_ext = {{mir_pkg::CNT_OUT_W{1'b0}}, divisor_r};
  assign no_pixels = (divisor_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_rmse_r  <= no_pixels ? '0 : root_r[mir_pkg::RMSE_W-1:0];
      out_count_r <= count_ext[mir_pkg::CNT_OUT_W-1:0];
      out_empty_r <= no_pixels;
    end
  end

  assign res_valid = out_valid_r;
  assign res_rmse  = out_rmse_r;
  assign res_count = out_count_r;
  assign res_empty = out_empty_r;

  // Status back to the controller.
  always_comb begin
    status           = '0;
    status.last_done = s2_valid_r && s2_last_r;
    status.out_free  = !out_valid_r || res_ready;
  end

endmodule

// ----- src/mir_checker.sv -----
// ----------------------------------------------------------------------------
// mir_checker
// Port-level checks of the masked image RMSE block, bound to the top level.
// ----------------------------------------------------------------------------
module mir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An empty image reports zero error and zero pixels.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 40'd0)
    else $error("empty result with nonzero payload");

  // After the last pixel of an image, pixel input closes while the result
  // is computed.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("pixel input still open after last pixel");

  // A new result never appears in the cycle after the last pixel.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && !out_tvalid |=> !out_tvalid)
    else $error("result appeared before computation");

endmodule

bind masked_image_rmse mir_checker u_mir_checker (.*);

// ----- dv/rmse_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmse_checker
// Watches the pixel and result channels of masked_image_rmse. It keeps its
// own image totals and computes the expected RMSE for every image. Each
// result that transfers is compared field by field with the oldest
// expected result.
// ----------------------------------------------------------------------------
module rmse_checker #(
  parameter int MAX_PIXELS   = 4194304,
  parameter int CHANNEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,   // test_red, test_green, test_blue, ref_red, ref_green, ref_blue
  input  logic        in_tuser,   // pixel_enabled
  input  logic        in_tlast,   // last_pixel
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // rmse_value [16:0], counted_pixels [39:17]
  input  logic        out_tuser,  // empty_flag
  output int          mismatch_count,
  output int          pending_count
);

  typedef struct packed {
    logic [mir_pkg::RMSE_W-1:0]    rmse;
    logic [mir_pkg::CNT_OUT_W-1:0] count;
    logic                          empty;
  } image_result_t;

  localparam logic [mir_pkg::CH_W-1:0] CHAN_MASK =
    mir_pkg::CH_W'((64'd1 << CHANNEL_BITS) - 1);

  image_result_t                 rmse_expected[$];
  logic [mir_pkg::SUM_W-1:0]     err_sum = '0;
  logic [mir_pkg::CNT_OUT_W-1:0] px_count = '0;
  int                            mismatches = 0;

  // Squared difference of one channel pair, exact as an unsigned integer (Q32.0).
  function automatic logic [mir_pkg::SUM_W-1:0] chan_sq_err(
    input logic [mir_pkg::CH_W-1:0] a,
    input logic [mir_pkg::CH_W-1:0] b);
    logic [mir_pkg::CH_W-1:0] am, bm, d;
    am = a & CHAN_MASK;
    bm = b & CHAN_MASK;
    d  = (am >= bm) ? am - bm : bm - am;
    return mir_pkg::SUM_W'(d) * mir_pkg::SUM_W'(d);
  endfunction

  // Addition that sticks at all ones on overflow.
  function automatic logic [mir_pkg::SUM_W-1:0] sum_sat(
    input logic [mir_pkg::SUM_W-1:0] a,
    input logic [mir_pkg::SUM_W-1:0] b);
    logic [mir_pkg::SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[mir_pkg::SUM_W] ? '1 : s[mir_pkg::SUM_W-1:0];
  endfunction

  // Floor of the square root, one result bit per trial from the top.
  function automatic logic [mir_pkg::ROOT_W-1:0] floor_sqrt(
    input logic [mir_pkg::SUM_W-1:0] v);
    logic [mir_pkg::ROOT_W-1:0] root, trial;
    root = '0;
    for (int i = mir_pkg::ROOT_W - 1; i >= 0; i--) begin
      trial = root | (mir_pkg::ROOT_W'(1) << i);
      if (mir_pkg::SUM_W'(trial) * mir_pkg::SUM_W'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  always @(posedge clk) begin
    logic [mir_pkg::CH_W-1:0]  ch [6];
    logic [mir_pkg::SUM_W-1:0] px_err;
    image_result_t             want, got;
    if (!rst_n) begin
      err_sum  = '0;
      px_count = '0;
    end else begin
      // Pixel transfer: accumulate, and close the image on its last pixel.
      if (in_tvalid && in_tready) begin
        for (int k = 0; k < 6; k++) ch[k] = in_tdata[k*mir_pkg::CH_W +: mir_pkg::CH_W];
        if (in_tuser && px_count < MAX_PIXELS) begin
          px_err   = chan_sq_err(ch[0], ch[3]);
          px_err   = sum_sat(px_err, chan_sq_err(ch[1], ch[4]));
          px_err   = sum_sat(px_err, chan_sq_err(ch[2], ch[5]));
          err_sum  = sum_sat(err_sum, px_err);
          px_count = px_count + 1'b1;
        end
        if (in_tlast) begin
          want.count = px_count;
          if (px_count == 0) begin
            want.rmse  = '0;
            want.empty = 1'b1;
          end else begin
            want.rmse  = mir_pkg::RMSE_W'(floor_sqrt(err_sum / mir_pkg::SUM_W'(px_count)));
            want.empty = 1'b0;
          end
          rmse_expected = {rmse_expected, want};
          err_sum  = '0;
          px_count = '0;
        end
      end

      // Result transfer: compare with the oldest expected image result.
      if (out_tvalid && out_tready) begin
        got.rmse  = out_tdata[mir_pkg::RMSE_W-1:0];
        got.count = out_tdata[mir_pkg::RMSE_W +: mir_pkg::CNT_OUT_W];
        got.empty = out_tuser;
        if (rmse_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: rmse=%0d count=%0d empty=%0b",
                     $realtime, got.rmse, got.count, got.empty);
        end else begin
          want = rmse_expected.pop_front();
          if (got.rmse != want.rmse || got.count != want.count ||
              got.empty != want.empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] result mismatch: rmse %0d/%0d count %0d/%0d empty %0b/%0b %s",
                       $realtime, want.rmse, got.rmse, want.count, got.count,
                       want.empty, got.empty, "(expected/actual)");
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= rmse_expected.size();
  end

endmodule

// ----- dv/masked_image_rmse_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_image_rmse_test
// Drives images of pixel pairs into masked_image_rmse: first directed edge
// cases, then random images in phases of sender idling and receiver
// stalling, with one long receiver hold-off. Checking is done by
// rmse_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module masked_image_rmse_test;

  localparam int LIMIT        = 400000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int TAIL_CYCLES  = 300;
  localparam int PHASE_PIXELS = 225;
  localparam logic [mir_pkg::CH_W-1:0] CH_MAX = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_trig = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   pending_count;

  always #4 clk = ~clk;

  masked_image_rmse dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  rmse_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_trig && !hold_used) begin
      hold_used  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one pixel after optional idle cycles; return once it transfers.
  task automatic push_pixel(input logic [mir_pkg::CH_W-1:0] tr,
                            input logic [mir_pkg::CH_W-1:0] tg,
                            input logic [mir_pkg::CH_W-1:0] tb,
                            input logic [mir_pkg::CH_W-1:0] rr,
                            input logic [mir_pkg::CH_W-1:0] rg,
                            input logic [mir_pkg::CH_W-1:0] rb,
                            input logic en, input logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rb, rg, rr, tb, tg, tr};
    in_tuser  <= en;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // One image with a random mask density and a random channel style.
  task automatic random_image(input int npix);
    int                       en_pct, style, pick;
    logic [mir_pkg::CH_W-1:0] t [3];
    logic [mir_pkg::CH_W-1:0] r [3];
    pick   = $urandom_range(9);
    en_pct = (pick == 0) ? 0 : (pick <= 3) ? 100 : $urandom_range(100);
    style  = $urandom_range(7);
    for (int p = 0; p < npix; p++) begin
      for (int c = 0; c < 3; c++) begin
        if (style == 1) begin
          // Channels at the extremes only.
          t[c] = $urandom_range(1) ? CH_MAX : '0;
          r[c] = $urandom_range(1) ? CH_MAX : '0;
        end else begin
          t[c] = mir_pkg::CH_W'($urandom_range(65535));
          if (style == 0) r[c] = t[c] + mir_pkg::CH_W'($urandom_range(64)) - mir_pkg::CH_W'(32);
          else            r[c] = mir_pkg::CH_W'($urandom_range(65535));
        end
      end
      push_pixel(t[0], t[1], t[2], r[0], r[1], r[2],
                 $urandom_range(99) < en_pct, p == npix - 1);
    end
  endtask

  initial begin
    int sent, npix;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed images with no idling.
    // Single masked pixel: no pixel counted, empty result.
    push_pixel(16'h1234, 16'h5678, 16'h9abc, 16'h0000, 16'hffff, 16'h0001, 1'b0, 1'b1);
    // Largest error in every channel, both directions.
    push_pixel(CH_MAX, CH_MAX, CH_MAX, '0, '0, '0, 1'b1, 1'b1);
    push_pixel('0, '0, '0, CH_MAX, CH_MAX, CH_MAX, 1'b1, 1'b1);
    // Identical pixels give zero error but still count.
    push_pixel(16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 1'b1, 1'b1);
    push_pixel('0, '0, '0, '0, '0, '0, 1'b1, 1'b1);
    // Several pixels, all masked.
    push_pixel(CH_MAX, '0, CH_MAX, '0, CH_MAX, '0, 1'b0, 1'b0);
    push_pixel('0, CH_MAX, '0, CH_MAX, '0, CH_MAX, 1'b0, 1'b0);
    push_pixel(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b1);
    // One channel differs in each counted pixel; the masked last pixel is not counted.
    push_pixel(CH_MAX, '0, '0, '0, '0, '0, 1'b1, 1'b0);
    push_pixel('0, CH_MAX, '0, '0, '0, '0, 1'b1, 1'b0);
    push_pixel('0, '0, CH_MAX, '0, '0, '0, 1'b1, 1'b0);
    push_pixel(CH_MAX, CH_MAX, CH_MAX, '0, '0, '0, 1'b0, 1'b1);
    // Small differences where the root of the mean is not a whole number.
    push_pixel(16'h0001, '0, '0, '0, '0, '0, 1'b1, 1'b0);
    push_pixel(16'h0002, 16'h0001, '0, '0, '0, '0, 1'b1, 1'b0);
    push_pixel('0, '0, 16'h0003, '0, '0, '0, 1'b1, 1'b1);

    // Random images in four phases of sender idling and receiver stalling.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          hold_trig <= 1'b1;
        end
        1: begin
          idle_pct = 66;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 66;
        end
        default: begin
          idle_pct = 10;
          stall_pct <= 10;
        end
      endcase
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        npix = ($urandom_range(15) == 0) ? $urandom_range(64, 17) : $urandom_range(12, 1);
        random_image(npix);
        sent += npix;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
